// File: hdl/idl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types and codes for the indexed deque list engine.
// ----------------------------------------------------------------------------
package idl_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_INS  = 2'd1,
    K_REM  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_I_ALLOC  = 4'd1,
    S_I_FREE   = 4'd2,
    S_WALK     = 4'd3,
    S_I_LINK   = 4'd4,
    S_I_LINK2  = 4'd5,
    S_R_READ   = 4'd6,
    S_R_UNLINK = 4'd7,
    S_R_FREE   = 4'd8,
    S_DONE     = 4'd9
  } state_t;

endpackage

// File: hdl/idl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module idl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/indexed_deque_list_engine_top.sv
`timescale 1ns / 1ps
// Sequence: errors and undefined ops go straight to the result; front and back inserts
//   and tail removal need no walk; other removes and inserts at 0 < P < length first
//   walk to P (P = position).
// Flow: one word at a time; the walk follows one next link per cycle, so its length grows
//   with the position, up to position CAPACITY - 2.
// Reset: synchronous; the list is empty and ready right after reset, with no RAM clearing pass.
// ----------------------------------------------------------------------------
// indexed_deque_list_engine_top
// Bounded doubly linked list of signed 32-bit elements kept in cell RAMs,
// driven by a small sequencer that walks the next links one step per cycle.
// ----------------------------------------------------------------------------
module indexed_deque_list_engine_top
  import idl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         status,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [POS_W-1:0]        length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  state_t state, state_next;

  kind_t               kind;
  status_t             st_q;
  logic [CW-1:0]       pos_q;
  logic [VAL_W-1:0]    val_q;
  logic [VAL_W-1:0]    rem_val;
  logic [CW-1:0]       count;
  logic [CW-1:0]       fh;
  logic [CW-1:0]       hwm;
  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [IW-1:0]       cur;
  logic [IW-1:0]       newc;
  logic [IW-1:0]       prev_q;
  logic [CW-1:0]       k;
  logic                primed;

  // RAM ports
  logic                nxt_we, prv_we, elem_we;
  logic [IW-1:0]       nxt_wa, prv_wa, elem_wa;
  logic [CW-1:0]       nxt_wd;
  logic [IW-1:0]       prv_wd;
  logic [VAL_W-1:0]    elem_wd;
  logic [IW-1:0]       nxt_ra, prv_ra, elem_ra;
  logic [CW-1:0]       nxt_rd;
  logic [IW-1:0]       prv_rd;
  logic [VAL_W-1:0]    elem_rd;

  // decode
  logic [WW-1:0]       cnt_w, pos_w, pw;
  kind_t               dec_kind;
  status_t             dec_st;
  logic                accept;
  logic                out_free;
  logic [IW-1:0]       cur_now;
  logic                is_head, is_tail, at_end, walk_done;
  logic [CW-1:0]       count_upd;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cur_now   = primed ? nxt_rd[IW-1:0] : cur;
  assign is_head   = (pos_q == '0);
  assign is_tail   = (pos_q == count - CW'(1));
  assign at_end    = (pos_q == count);
  assign walk_done = (k == pos_q);

  always_comb begin
    cnt_w    = WW'(count);
    pos_w    = WW'(position);
    pw       = '0;
    dec_kind = K_NONE;
    dec_st   = ST_OK;
    case (op_t'(op))
      OP_INS_FRONT: begin
        dec_kind = K_INS;
        pw       = '0;
      end
      OP_INS_BACK: begin
        dec_kind = K_INS;
        pw       = cnt_w;
      end
      OP_INS_AT: begin
        dec_kind = K_INS;
        pw       = pos_w;
      end
      OP_REM_FRONT: begin
        dec_kind = K_REM;
        pw       = '0;
      end
      OP_REM_BACK: begin
        dec_kind = K_REM;
        pw       = cnt_w - WW'(1);
      end
      OP_REM_AT: begin
        dec_kind = K_REM;
        pw       = pos_w;
      end
      default: begin
        dec_kind = K_NONE;
        pw       = '0;
      end
    endcase
    if (dec_kind == K_INS) begin
      if (pw > cnt_w) begin
        dec_st = ST_BAD_POS;
      end else if (count == CW'(CAPACITY)) begin
        dec_st = ST_FULL;
      end
    end else if (dec_kind == K_REM) begin
      if (count == '0) begin
        dec_st = ST_EMPTY;
      end else if (pw >= cnt_w) begin
        dec_st = ST_BAD_POS;
      end
    end
    // rejected requests leave the list alone
    if (dec_st != ST_OK) begin
      dec_kind = K_NONE;
    end
  end

  always_comb begin
    count_upd = count;
    if (kind == K_INS) begin
      count_upd = count + CW'(1);
    end else if (kind == K_REM) begin
      count_upd = count - CW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (dec_kind)
            K_INS:   state_next = S_I_ALLOC;
            K_REM:   state_next = (pw == cnt_w - WW'(1)) ? S_R_READ : S_WALK;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_I_ALLOC:  state_next = S_I_FREE;
      S_I_FREE: begin
        if (count == '0 || is_head || at_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = (kind == K_INS) ? S_I_LINK : S_R_READ;
        end
      end
      S_I_LINK:   state_next = S_I_LINK2;
      S_I_LINK2:  state_next = S_DONE;
      S_R_READ:   state_next = S_R_UNLINK;
      S_R_UNLINK: state_next = S_R_FREE;
      S_R_FREE:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    nxt_we  = 1'b0;
    nxt_wa  = cur;
    nxt_wd  = '0;
    nxt_ra  = cur;
    prv_we  = 1'b0;
    prv_wa  = cur;
    prv_wd  = '0;
    prv_ra  = cur;
    elem_we = 1'b0;
    elem_wa = fh[IW-1:0];
    elem_wd = val_q;
    elem_ra = cur;
    case (state)
      S_I_ALLOC: begin
        nxt_ra  = fh[IW-1:0];
        elem_we = 1'b1;
      end
      S_I_FREE: begin
        if (count != '0) begin
          if (is_head) begin
            nxt_we = 1'b1;
            nxt_wa = fh[IW-1:0];
            nxt_wd = CW'(head);
            prv_we = 1'b1;
            prv_wa = head;
            prv_wd = fh[IW-1:0];
          end else if (at_end) begin
            prv_we = 1'b1;
            prv_wa = fh[IW-1:0];
            prv_wd = tail;
            nxt_we = 1'b1;
            nxt_wa = tail;
            nxt_wd = fh;
          end
        end
      end
      S_WALK: begin
        nxt_ra = cur_now;
        prv_ra = cur_now;
      end
      S_I_LINK: begin
        nxt_we = 1'b1;
        nxt_wa = prv_rd;
        nxt_wd = CW'(newc);
        prv_we = 1'b1;
        prv_wa = cur;
        prv_wd = newc;
      end
      S_I_LINK2: begin
        nxt_we = 1'b1;
        nxt_wa = newc;
        nxt_wd = CW'(cur);
        prv_we = 1'b1;
        prv_wa = newc;
        prv_wd = prev_q;
      end
      S_R_UNLINK: begin
        // bridge the neighbors around the removed cell
        if (!is_head) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd;
          nxt_wd = nxt_rd;
        end
        if (!is_tail) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[IW-1:0];
          prv_wd = prv_rd;
        end
      end
      S_R_FREE: begin
        nxt_we = 1'b1;
        nxt_wa = cur;
        nxt_wd = fh;
      end
      default: begin
        nxt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_NONE;
      count     <= '0;
      fh        <= '0;
      hwm       <= '0;
      head      <= '0;
      tail      <= '0;
      k         <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind    <= dec_kind;
            st_q    <= dec_st;
            pos_q   <= CW'(pw);
            val_q   <= value;
            rem_val <= '0;
            k       <= '0;
            primed  <= 1'b0;
            cur     <= (pw == cnt_w - WW'(1)) ? tail : head;
          end
        end
        S_I_FREE: begin
          newc <= fh[IW-1:0];
          // cells at or above the fill count have never been used
          if (fh == hwm) begin
            fh  <= fh + CW'(1);
            hwm <= hwm + CW'(1);
          end else begin
            fh <= nxt_rd;
          end
          if (count == '0) begin
            head <= fh[IW-1:0];
            tail <= fh[IW-1:0];
          end else if (is_head) begin
            head <= fh[IW-1:0];
          end else if (at_end) begin
            tail <= fh[IW-1:0];
          end
          cur    <= head;
          k      <= '0;
          primed <= 1'b0;
        end
        S_WALK: begin
          cur <= cur_now;
          if (!walk_done) begin
            k      <= k + CW'(1);
            primed <= 1'b1;
          end
        end
        S_I_LINK: begin
          prev_q <= prv_rd;
        end
        S_R_UNLINK: begin
          rem_val <= elem_rd;
          if (is_head) begin
            head <= nxt_rd[IW-1:0];
          end
          if (is_tail) begin
            tail <= prv_rd;
          end
        end
        S_R_FREE: begin
          fh <= CW'(cur);
        end
        default: begin
          k <= k;
        end
      endcase

      if (state == S_DONE && out_free) begin
        count         <= count_upd;
        out_valid     <= 1'b1;
        status        <= st_q;
        removed_value <= rem_val;
        length        <= POS_W'(count_upd);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  idl_ram #(.DEPTH(CAPACITY), .WIDTH(CW)) u_nxt (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_wa),
    .wdata (nxt_wd),
    .raddr (nxt_ra),
    .rdata (nxt_rd)
  );

  idl_ram #(.DEPTH(CAPACITY), .WIDTH(IW)) u_prv (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_wa),
    .wdata (prv_wd),
    .raddr (prv_ra),
    .rdata (prv_rd)
  );

  idl_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_elem (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_wa),
    .wdata (elem_wd),
    .raddr (elem_ra),
    .rdata (elem_rd)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_fill_cover: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count <= hwm && hwm <= CW'(CAPACITY)))
    else $error("fill count does not cover the live cells");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (k <= pos_q))
    else $error("list walk ran past its target");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (removed_value == '0))
    else $error("removed value set on a failed request");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (length == '0))
    else $error("empty status with nonzero length");
`endif

endmodule

// File: sim/deque_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_list_checker
// Watches the request and result channels of the list engine, keeps its own
// copy of the list as a queue of elements, and compares every returned word
// field by field against the predicted outcome, oldest first.
// ----------------------------------------------------------------------------
module deque_list_checker
  import idl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [ST_W-1:0]         status,
  input  logic signed [VAL_W-1:0] removed_value,
  input  logic [POS_W-1:0]        length,
  output int                      mismatch_count,
  output int                      outstanding,
  output int                      held_count
);

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [POS_W-1:0]        length;
  } outcome_t;

  logic signed [VAL_W-1:0] model_list[$];
  outcome_t                outcome_q[$];
  int                      errs = 0;

  // Apply one request to the model list and return the word it should produce.
  function automatic outcome_t list_outcome(input logic [OP_W-1:0]         req_op,
                                            input logic [POS_W-1:0]        req_pos,
                                            input logic signed [VAL_W-1:0] req_val);
    outcome_t o;
    int       slot;
    o.status        = ST_OK;
    o.removed_value = '0;
    slot            = 0;
    case (req_op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (req_op == OP_INS_BACK)
          slot = model_list.size();
        else if (req_op == OP_INS_AT)
          slot = int'(req_pos);
        // a bad position wins over a full list
        if (slot > model_list.size())
          o.status = ST_BAD_POS;
        else if (model_list.size() >= CAPACITY)
          o.status = ST_FULL;
        else
          model_list.insert(slot, req_val);
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        if (req_op == OP_REM_BACK)
          slot = model_list.size() - 1;
        else if (req_op == OP_REM_AT)
          slot = int'(req_pos);
        if (model_list.size() == 0)
          o.status = ST_EMPTY;
        else if (slot >= model_list.size())
          o.status = ST_BAD_POS;
        else begin
          o.removed_value = model_list[slot];
          model_list.delete(slot);
        end
      end
      default: ;  // undefined codes leave the list alone
    endcase
    o.length = POS_W'(model_list.size());
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      model_list.delete();
      outcome_q.delete();
    end else begin
      // check the result first: it always belongs to an older request
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected word: status %0d removed %0d length %0d",
                     $realtime, status, removed_value, length);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status || removed_value !== want.removed_value ||
              length !== want.length) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: expected status %0d removed %0d length %0d, got status %0d removed %0d length %0d",
                       $realtime, want.status, want.removed_value, want.length,
                       status, removed_value, length);
          end
        end
      end
      if (in_valid && in_ready)
        outcome_q.push_back(list_outcome(op, position, value));
    end
    mismatch_count <= errs;
    outstanding    <= outcome_q.size();
    held_count     <= model_list.size();
  end

endmodule

// File: sim/indexed_deque_list_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_list_engine_top_tb
// Drives front, back and positional inserts and removes into the list
// engine: a directed opening for the error cases and boundaries, then random
// grow and shrink runs that fill and empty the list under varying idling and stalls.
// ----------------------------------------------------------------------------
module indexed_deque_list_engine_top_tb;
  import idl_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int RANDOM_WORDS  = 750;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_GAP       = 30;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         op        = '0;
  logic [POS_W-1:0]        position  = '0;
  logic signed [VAL_W-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] removed_value;
  logic [POS_W-1:0]        length;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;
  int mismatches;
  int outstanding;
  int held;
  bit growing        = 1'b1;

  indexed_deque_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .removed_value(removed_value),
    .length(length)
  );

  deque_list_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .removed_value(removed_value),
    .length(length),
    .mismatch_count(mismatches),
    .outstanding(outstanding),
    .held_count(held)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold the word until accepted, then maybe go idle for a random gap.
  task automatic send_word(input logic [OP_W-1:0]  w_op,
                           input logic [POS_W-1:0] w_pos,
                           input logic [VAL_W-1:0] w_val);
    int gap;
    gap = 0;
    op       <= w_op;
    position <= w_pos;
    value    <= w_val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  task automatic send_random_word();
    int               len;
    bit               insert;
    logic [OP_W-1:0]  w_op;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_val;
    len = held;
    // swing between filling and emptying so both ends get hit
    if (growing && len >= CAPACITY && $urandom_range(3) == 0)
      growing = 1'b0;
    else if (!growing && len == 0 && $urandom_range(3) == 0)
      growing = 1'b1;
    else if ($urandom_range(99) < 2)
      growing = !growing;
    insert = growing ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
    case ($urandom_range(2))
      0:       w_op = insert ? OP_INS_FRONT : OP_REM_FRONT;
      1:       w_op = insert ? OP_INS_BACK : OP_REM_BACK;
      default: w_op = insert ? OP_INS_AT : OP_REM_AT;
    endcase
    if ($urandom_range(99) < 3)
      w_op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    case ($urandom_range(19))
      0, 1:    w_pos = POS_W'($urandom_range(127));
      2:       w_pos = POS_W'(len + 1);
      3:       w_pos = POS_W'(len);
      default: w_pos = insert ? POS_W'($urandom_range(len))
                              : POS_W'($urandom_range(len > 0 ? len - 1 : 0));
    endcase
    case ($urandom_range(9))
      0:       w_val = 32'h7fffffff;
      1:       w_val = 32'h80000000;
      default: w_val = $urandom();
    endcase
    send_word(w_op, w_pos, w_val);
  endtask

  task automatic run_phase(input int words, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) send_random_word();
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list: every remove flavor, and inserts past the end
    send_word(OP_REM_FRONT, 7'd0, 32'hdeadbeef);
    send_word(OP_REM_BACK, 7'd0, 32'h0);
    send_word(OP_REM_AT, 7'd0, 32'h0);
    send_word(OP_REM_AT, 7'd127, 32'hffffffff);
    send_word(OP_INS_AT, 7'd1, 32'h12345678);
    send_word(OP_INS_AT, 7'd127, 32'h12345678);
    // build a short list with the value extremes
    send_word(OP_INS_FRONT, 7'd127, 32'h7fffffff);
    send_word(OP_INS_BACK, 7'd85, 32'h80000000);
    send_word(OP_INS_AT, 7'd1, 32'hffffffff);
    send_word(OP_INS_AT, 7'd0, 32'h00000000);
    send_word(OP_INS_AT, 7'd4, 32'h00000001);
    send_word(OP_INS_AT, 7'd2, 32'ha5a5a5a5);
    send_word(OP_SPARE_6, 7'd127, 32'hffffffff);
    send_word(OP_SPARE_7, 7'd0, 32'h5a5a5a5a);
    // remove positions at and past the end, then from the middle and ends
    send_word(OP_REM_AT, 7'd6, 32'h0);
    send_word(OP_REM_AT, 7'd127, 32'h0);
    send_word(OP_REM_AT, 7'd3, 32'hffffffff);
    send_word(OP_REM_AT, 7'd4, 32'h0);
    send_word(OP_REM_FRONT, 7'd127, 32'h0);
    send_word(OP_REM_BACK, 7'd127, 32'h0);
    send_word(OP_REM_AT, 7'd0, 32'h0);
    send_word(OP_INS_AT, 7'd2, 32'h0);
    drain_results();

    run_phase(RANDOM_WORDS / 4, 0, 0);
    run_phase(RANDOM_WORDS / 4, 50, 0);
    run_phase(RANDOM_WORDS / 4, 0, 50);
    run_phase(RANDOM_WORDS / 4, 31, 31);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
hdl/idl_pkg.sv
hdl/idl_ram.sv
hdl/indexed_deque_list_engine_top.sv
sim/deque_list_checker.sv
sim/indexed_deque_list_engine_top_tb.sv
